@@ rtl/core/rwsd_pkg.sv @@
package rwsd_pkg;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_OPCODE = 2'd0,
        PH_OPLO   = 2'd1,
        PH_OPHI   = 2'd2,
        PH_DATA   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] reg_address;
        logic [31:0] reg_value;
        logic [2:0]  write_bytes;
        logic        chunk_end;
    } t_result;

    localparam logic [7:0] OP_GROUP_LO  = 8'hA0;
    localparam logic [7:0] OP_GROUP_HI  = 8'hAF;
    localparam logic [7:0] OP_CONT_LO   = 8'h50;
    localparam logic [7:0] OP_CONT_HI   = 8'h5F;
    localparam logic [7:0] OP_UPPER     = 8'hB0;
    localparam logic [4:0] GROUP_MAX    = 5'd16;
    localparam logic [2:0] HDR_LEN      = 3'd5;
    localparam logic [2:0] HDR_UPPER_LO = 3'd3;
    localparam logic [2:0] HDR_UPPER_HI = 3'd4;
    localparam logic [3:0] MIN_CHUNK    = 4'd8;
    localparam logic [2:0] BYTES_WORD   = 3'd4;
    localparam logic [2:0] BYTES_ONE    = 3'd1;

endpackage

@@ rtl/core/rwsd_in_reg.sv @@
module rwsd_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last_byte,
    input  logic          i_consume,
    output logic          o_valid,
    output rwsd_pkg::t_item o_item
);
    import rwsd_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  accept;

    assign accept     = i_in_valid && (!r_valid || i_consume);
    assign o_in_stall = r_valid && !i_consume;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_consume) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.data_byte <= i_data_byte;
            r_item.last_byte <= i_last_byte;
        end
    end

endmodule

@@ rtl/core/rwsd_decode.sv @@
module rwsd_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  rwsd_pkg::t_item   i_item,
    output logic              o_res_valid,
    output rwsd_pkg::t_result o_res
);
    import rwsd_pkg::*;

    logic [2:0]  r_hdr,    n_hdr;
    t_phase      r_phase,  n_phase;
    logic [15:0] r_upper,  n_upper;
    logic [31:0] r_base,   n_base;
    logic [4:0]  r_len,    n_len;
    logic [4:0]  r_off,    n_off;
    logic [31:0] r_gather, n_gather;
    logic [1:0]  r_fill,   n_fill;
    logic [7:0]  r_hold,   n_hold;
    logic        r_prefix, n_prefix;
    logic        r_error,  n_error;
    logic [3:0]  r_short,  n_short;

    logic [7:0]  b;
    logic        do_take;
    logic        restart;
    logic [4:0]  tk_off;
    logic [1:0]  tk_fill;
    logic [31:0] tk_gather;
    logic [31:0] tk_merged;
    logic [4:0]  rem;
    logic [31:0] w_addr;
    logic [31:0] w_value;
    logic [2:0]  w_bytes;
    logic        w_valid;
    logic        err;
    t_result     res;

    assign b = i_item.data_byte;

    always_comb begin
        n_hdr    = r_hdr;
        n_phase  = r_phase;
        n_upper  = r_upper;
        n_base   = r_base;
        n_len    = r_len;
        n_off    = r_off;
        n_gather = r_gather;
        n_fill   = r_fill;
        n_hold   = r_hold;
        n_prefix = r_prefix;
        n_error  = r_error;
        n_short  = (r_short < MIN_CHUNK) ? r_short + 4'd1 : r_short;
        do_take  = 1'b0;
        restart  = 1'b0;

        if (!r_error) begin
            if (r_hdr < HDR_LEN) begin
                if (r_hdr == HDR_UPPER_LO) begin
                    n_hold = b;
                end else if (r_hdr == HDR_UPPER_HI) begin
                    n_upper = {b, r_hold};
                end
                n_hdr = r_hdr + 3'd1;
            end else begin
                case (r_phase)
                    PH_OPCODE: begin
                        if (b inside {[OP_GROUP_LO:OP_GROUP_HI]}) begin
                            n_len    = {1'b0, b[3:0]} + 5'd1;
                            n_prefix = 1'b0;
                            n_phase  = PH_OPLO;
                        end else if (b inside {[OP_CONT_LO:OP_CONT_HI]} &&
                                     r_len == GROUP_MAX) begin
                            n_len    = {1'b0, b[3:0]} + 5'd1;
                            n_base   = r_base + 32'd16;
                            n_off    = 5'd0;
                            n_fill   = 2'd0;
                            n_gather = 32'd0;
                            n_phase  = PH_DATA;
                        end else if (b == OP_UPPER) begin
                            n_prefix = 1'b1;
                            n_phase  = PH_OPLO;
                        end else if (r_len == 5'd0) begin
                            n_error = 1'b1;
                        end else begin
                            // repeat of the last group, this byte is its first data
                            do_take = 1'b1;
                            restart = 1'b1;
                        end
                    end
                    PH_OPLO: begin
                        n_hold  = b;
                        n_phase = PH_OPHI;
                    end
                    PH_OPHI: begin
                        if (r_prefix) begin
                            n_upper  = {b, r_hold};
                            n_prefix = 1'b0;
                            n_phase  = PH_OPCODE;
                        end else begin
                            n_base   = {16'd0, b, r_hold};
                            n_off    = 5'd0;
                            n_fill   = 2'd0;
                            n_gather = 32'd0;
                            n_phase  = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        do_take = 1'b1;
                    end
                    default: begin
                        n_phase = PH_OPCODE;
                    end
                endcase
            end
        end

        tk_off    = restart ? 5'd0  : r_off;
        tk_fill   = restart ? 2'd0  : r_fill;
        tk_gather = restart ? 32'd0 : r_gather;
        rem       = r_len - tk_off;
        w_addr    = {r_upper, 16'd0} + r_base + {27'd0, tk_off};
        tk_merged = tk_gather | ({24'd0, b} << {tk_fill, 3'b000});
        w_valid   = 1'b0;
        w_value   = {24'd0, b};
        w_bytes   = BYTES_ONE;

        if (do_take) begin
            if (rem >= 5'd4) begin
                if (tk_fill == 2'd3) begin
                    w_valid  = 1'b1;
                    w_value  = tk_merged;
                    w_bytes  = BYTES_WORD;
                    n_off    = tk_off + 5'd4;
                    n_fill   = 2'd0;
                    n_gather = 32'd0;
                end else begin
                    n_off    = tk_off;
                    n_fill   = tk_fill + 2'd1;
                    n_gather = tk_merged;
                end
            end else begin
                w_valid  = 1'b1;
                n_off    = tk_off + 5'd1;
                n_fill   = tk_fill;
                n_gather = tk_gather;
            end
            n_phase = (n_off >= r_len) ? PH_OPCODE : PH_DATA;
        end

        err = n_error || (n_short < MIN_CHUNK) || (n_hdr < HDR_LEN) ||
              (n_phase != PH_OPCODE);

        res.kind        = KIND_WRITE;
        res.reg_address = w_addr;
        res.reg_value   = w_value;
        res.write_bytes = w_bytes;
        res.chunk_end   = i_item.last_byte;
        if (i_item.last_byte && (err || !w_valid)) begin
            res.kind        = err ? KIND_ERROR : KIND_END;
            res.reg_address = 32'd0;
            res.reg_value   = 32'd0;
            res.write_bytes = 3'd0;
        end

        if (i_item.last_byte) begin
            n_hdr    = 3'd0;
            n_phase  = PH_OPCODE;
            n_upper  = 16'd0;
            n_base   = 32'd0;
            n_len    = 5'd0;
            n_off    = 5'd0;
            n_gather = 32'd0;
            n_fill   = 2'd0;
            n_hold   = 8'd0;
            n_prefix = 1'b0;
            n_error  = 1'b0;
            n_short  = 4'd0;
        end
    end

    assign o_res_valid = w_valid || i_item.last_byte;
    assign o_res       = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr    <= 3'd0;
            r_phase  <= PH_OPCODE;
            r_upper  <= 16'd0;
            r_base   <= 32'd0;
            r_len    <= 5'd0;
            r_off    <= 5'd0;
            r_gather <= 32'd0;
            r_fill   <= 2'd0;
            r_hold   <= 8'd0;
            r_prefix <= 1'b0;
            r_error  <= 1'b0;
            r_short  <= 4'd0;
        end else if (i_fire) begin
            r_hdr    <= n_hdr;
            r_phase  <= n_phase;
            r_upper  <= n_upper;
            r_base   <= n_base;
            r_len    <= n_len;
            r_off    <= n_off;
            r_gather <= n_gather;
            r_fill   <= n_fill;
            r_hold   <= n_hold;
            r_prefix <= n_prefix;
            r_error  <= n_error;
            r_short  <= n_short;
        end
    end

endmodule

@@ rtl/core/rwsd_out_reg.sv @@
module rwsd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  rwsd_pkg::t_result i_res,
    output logic              o_ready,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rwsd_pkg::t_result o_res
);
    import rwsd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready     = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

@@ rtl/core/register_write_stream_decoder.sv @@
// Bytes pass the input register, combinational decode and the output register in order.
// Throughput: one byte per cycle unless stalled; only writes and chunk ends make results.
// The decode state updates on the edge that consumes a byte from the input register.
// Reset (synchronous, active low) empties both registers and returns the decoder
// to the start of a chunk; each chunk end does the same for the decoder state.
module register_write_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [31:0] o_reg_address,
    output logic [31:0] o_reg_value,
    output logic [2:0]  o_write_bytes,
    output logic        o_chunk_end
);
    import rwsd_pkg::*;

    logic    item_valid;
    t_item   item;
    logic    out_ready;
    logic    consume;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign consume = item_valid && out_ready;

    rwsd_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_consume   (consume),
        .o_valid     (item_valid),
        .o_item      (item)
    );

    rwsd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (consume),
        .i_item      (item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rwsd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (consume && res_valid),
        .i_res       (res),
        .o_ready     (out_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (out_res)
    );

    assign o_kind        = out_res.kind;
    assign o_reg_address = out_res.reg_address;
    assign o_reg_value   = out_res.reg_value;
    assign o_write_bytes = out_res.write_bytes;
    assign o_chunk_end   = out_res.chunk_end;

endmodule

@@ rtl/core/rwsd_checker.sv @@
module rwsd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_kind,
    input logic [31:0] o_reg_address,
    input logic [31:0] o_reg_value,
    input logic [2:0]  o_write_bytes,
    input logic        o_chunk_end
);
    import rwsd_pkg::*;

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind) &&
        $stable(o_reg_address) && $stable(o_reg_value) &&
        $stable(o_write_bytes) && $stable(o_chunk_end))
        else $error("stalled result changed");

    a_write_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_WRITE |->
        (o_write_bytes == BYTES_ONE || o_write_bytes == BYTES_WORD))
        else $error("write with bad byte count");

    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_WRITE |-> o_chunk_end &&
        o_reg_address == 32'd0 && o_reg_value == 32'd0 && o_write_bytes == 3'd0)
        else $error("chunk end or error result malformed");

    a_byte_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_WRITE && o_write_bytes == BYTES_ONE |->
        o_reg_value[31:8] == 24'd0)
        else $error("single-byte write value too wide");

endmodule

bind register_write_stream_decoder rwsd_checker u_rwsd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_kind        (o_kind),
    .o_reg_address (o_reg_address),
    .o_reg_value   (o_reg_value),
    .o_write_bytes (o_write_bytes),
    .o_chunk_end   (o_chunk_end)
);
